/* design/assert_macros.svh */
// Assertion macros for the checker file of this project.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is held off while reset is active.
`define EGCD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define EGCD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/egcd_pkg.sv */
// Package for the ellipsoid great circle distance unit: constants, ellipsoid table,
// CORDIC arctangent table. No dependencies.
`default_nettype none

package egcd_pkg;

    localparam int CORDIC_STAGES_DEF = 32;
    localparam int ISQ_STAGES        = 31;   // one result bit of the square root per stage
    localparam int ZW                = 34;   // CORDIC datapath width (Q2.30 plus headroom)

    localparam logic signed [ZW-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic [24:0]          RAD_PER_UDEG = 25'd19650660;

    localparam logic signed [27:0] LAT_MAX    = 28'sd90000000;
    localparam logic [28:0]        FULL_TURN  = 29'd360000000;
    localparam logic [28:0]        HALF_TURN  = 29'd180000000;
    localparam logic [27:0]        QUART_TURN = 28'd90000000;

    typedef enum logic [1:0] {
        ELL_WGS84         = 2'd0,
        ELL_CLARKE_EXACT  = 2'd1,
        ELL_CLARKE_DEF    = 2'd2,
        ELL_RESERVED      = 2'd3
    } t_ellipsoid;

    // Semi-major axis in millimetres.
    function automatic logic [32:0] f_axis_mm(input t_ellipsoid sel);
        logic [32:0] v;
        unique case (sel)
            ELL_WGS84: v = 33'd6378137000;
            default:   v = 33'd6378206400;
        endcase
        return v;
    endfunction

    // Flattening in Q40; the reserved code behaves as the default Clarke set.
    function automatic logic [31:0] f_flat_q40(input t_ellipsoid sel);
        logic [31:0] v;
        unique case (sel)
            ELL_WGS84:        v = 32'd3686454311;
            ELL_CLARKE_EXACT: v = 32'd3727427216;
            default:          v = 32'd3727411772;
        endcase
        return v;
    endfunction

    // atan(2^-i) in Q30.
    function automatic logic signed [ZW-1:0] f_atan(input int i);
        logic signed [ZW-1:0] v;
        unique case (i)
            0: v = 34'sd843314857;
            1: v = 34'sd497837829;
            2: v = 34'sd263043837;
            3: v = 34'sd133525159;
            4: v = 34'sd67021687;
            5: v = 34'sd33543516;
            6: v = 34'sd16775851;
            7: v = 34'sd8388437;
            8: v = 34'sd4194283;
            9: v = 34'sd2097149;
            default: begin
                if (i <= 30) v = 34'sd1 <<< (30 - i);
                else         v = '0;
            end
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

/* design/ellipsoid_great_circle_distance_unit.sv */
// Top level of the ellipsoid great circle distance unit: fully pipelined datapath.
// Depends on egcd_pkg.
`default_nettype none
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+------------------------------------------
//  request  | in        | i_valid / o_ready   | i_lat_first, i_lon_first, i_lat_second,
//           |           |                     | i_lon_second (signed microdegrees)
//  result   | out       | o_valid / i_ready   | o_distance_mm (unsigned millimetres)
//  config   | in        | i_cfg_we            | i_cfg_data (ellipsoid select)
//
//  One request enters per cycle while the pipeline advances; each result passes through the
//  two CORDIC chains and the 31-step square root. The whole pipeline advances together; a
//  full output register that is not taken freezes every stage, so nothing is dropped or
//  repeated and bubbles hold their place.
//  Synchronous active-low reset clears the valid bits and selects the default ellipsoid.
//
module ellipsoid_great_circle_distance_unit #(
    parameter int CORDIC_STAGES = egcd_pkg::CORDIC_STAGES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [27:0] i_lat_first,
    input  wire logic [28:0] i_lon_first,
    input  wire logic [27:0] i_lat_second,
    input  wire logic [28:0] i_lon_second,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [33:0]      o_distance_mm,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_data
);
    import egcd_pkg::*;

    localparam int N   = CORDIC_STAGES;
    localparam int LAT = 44 + 2 * N;
    localparam int RDP = ISQ_STAGES + N;

    logic            w_adv;
    logic [LAT-1:0]  r_vld;
    t_ellipsoid      r_sel;

    // Advance whenever the output slot is free or being emptied.
    assign w_adv   = !r_vld[LAT-1] || i_ready;
    assign o_ready = w_adv;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel <= ELL_CLARKE_DEF;
        end else if (i_cfg_we) begin
            r_sel <= t_ellipsoid'(i_cfg_data);
        end
    end

    // ---------------------------------------------------------------
    // S1: saturate latitudes, absolute longitude difference
    // ---------------------------------------------------------------
    logic signed [27:0] r_p1, r_p2, n_p1, n_p2;
    logic [28:0]        r_dabs, n_dabs;
    logic signed [29:0] w_dl;

    always_comb begin
        n_p1 = $signed(i_lat_first);
        if (n_p1 > LAT_MAX)       n_p1 = LAT_MAX;
        else if (n_p1 < -LAT_MAX) n_p1 = -LAT_MAX;
        n_p2 = $signed(i_lat_second);
        if (n_p2 > LAT_MAX)       n_p2 = LAT_MAX;
        else if (n_p2 < -LAT_MAX) n_p2 = -LAT_MAX;
        w_dl   = 30'($signed(i_lon_second)) - 30'($signed(i_lon_first));
        n_dabs = w_dl[29] ? 29'(-w_dl) : w_dl[28:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_p1   <= n_p1;
            r_p2   <= n_p2;
            r_dabs <= n_dabs;
        end
    end

    // ---------------------------------------------------------------
    // S2: reduce modulo a full turn, fold to half a turn, split signs
    // ---------------------------------------------------------------
    logic [26:0] r_m1, r_m2;
    logic        r_sg1, r_sg2;
    logic [27:0] r_df;
    logic [28:0] w_dm;

    always_comb begin
        w_dm = (r_dabs >= FULL_TURN) ? r_dabs - FULL_TURN : r_dabs;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sg1 <= r_p1[27];
            r_sg2 <= r_p2[27];
            r_m1  <= r_p1[27] ? 27'(-r_p1) : r_p1[26:0];
            r_m2  <= r_p2[27] ? 27'(-r_p2) : r_p2[26:0];
            r_df  <= (w_dm > HALF_TURN) ? 28'(FULL_TURN - w_dm) : w_dm[27:0];
        end
    end

    // ---------------------------------------------------------------
    // S3: beyond a quarter turn, rotate by the excess and use -sin
    // ---------------------------------------------------------------
    logic [26:0] r_m1b, r_m2b, r_dq;
    logic        r_sg1b, r_sg2b, r_q3;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_m1b  <= r_m1;
            r_m2b  <= r_m2;
            r_sg1b <= r_sg1;
            r_sg2b <= r_sg2;
            r_q3   <= r_df > QUART_TURN;
            r_dq   <= (r_df > QUART_TURN) ? 27'(r_df - QUART_TURN) : r_df[26:0];
        end
    end

    // ---------------------------------------------------------------
    // S4: microdegrees times radians per microdegree (Q50)
    // ---------------------------------------------------------------
    logic [51:0] r_pr1, r_pr2, r_prd;
    logic        r_sg1c, r_sg2c, r_q4;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_pr1  <= 52'(r_m1b) * 52'(RAD_PER_UDEG);
            r_pr2  <= 52'(r_m2b) * 52'(RAD_PER_UDEG);
            r_prd  <= 52'(r_dq) * 52'(RAD_PER_UDEG);
            r_sg1c <= r_sg1b;
            r_sg2c <= r_sg2b;
            r_q4   <= r_q3;
        end
    end

    // ---------------------------------------------------------------
    // S5: round to Q30 radians, restore sign
    // ---------------------------------------------------------------
    logic signed [31:0] r_r1, r_r2, r_rd;
    logic               r_q5;
    logic [52:0]        w_s1, w_s2, w_sd;

    always_comb begin
        w_s1 = 53'(r_pr1) + 53'(1 << 19);
        w_s2 = 53'(r_pr2) + 53'(1 << 19);
        w_sd = 53'(r_prd) + 53'(1 << 19);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_r1 <= r_sg1c ? -$signed(w_s1[51:20]) : $signed(w_s1[51:20]);
            r_r2 <= r_sg2c ? -$signed(w_s2[51:20]) : $signed(w_s2[51:20]);
            r_rd <= $signed(w_sd[51:20]);
            r_q5 <= r_q4;
        end
    end

    // ---------------------------------------------------------------
    // S6: mean latitude; lane order phi1, phi2, mean, delta-lambda
    // ---------------------------------------------------------------
    logic signed [31:0] r_z6 [4];
    logic               r_q6;
    logic signed [32:0] w_sum12;

    assign w_sum12 = 33'(r_r1) + 33'(r_r2);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_z6[0] <= r_r1;
            r_z6[1] <= r_r2;
            r_z6[2] <= 32'(w_sum12 >>> 1);
            r_z6[3] <= r_rd;
            r_q6    <= r_q5;
        end
    end

    // ---------------------------------------------------------------
    // Rotation CORDIC: four lanes, one iteration per stage
    // ---------------------------------------------------------------
    logic signed [ZW-1:0] r_rx [N][4];
    logic signed [ZW-1:0] r_ry [N][4];
    logic signed [ZW-1:0] r_rz [N][4];
    logic [N-1:0]         r_qp;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_qp <= {r_qp[N-2:0], r_q6};
        end
    end

    for (genvar g = 0; g < N; g++) begin : g_rot
        logic signed [ZW-1:0] w_x [4];
        logic signed [ZW-1:0] w_y [4];
        logic signed [ZW-1:0] w_z [4];
        logic signed [ZW-1:0] n_x [4];
        logic signed [ZW-1:0] n_y [4];
        logic signed [ZW-1:0] n_z [4];

        always_comb begin
            for (int ln = 0; ln < 4; ln++) begin
                if (g == 0) begin
                    w_x[ln] = CORDIC_GAIN;
                    w_y[ln] = '0;
                    w_z[ln] = ZW'(r_z6[ln]);
                end else begin
                    w_x[ln] = r_rx[g-1][ln];
                    w_y[ln] = r_ry[g-1][ln];
                    w_z[ln] = r_rz[g-1][ln];
                end
                if (w_z[ln] >= 0) begin
                    n_x[ln] = w_x[ln] - (w_y[ln] >>> g);
                    n_y[ln] = w_y[ln] + (w_x[ln] >>> g);
                    n_z[ln] = w_z[ln] - f_atan(g);
                end else begin
                    n_x[ln] = w_x[ln] + (w_y[ln] >>> g);
                    n_y[ln] = w_y[ln] - (w_x[ln] >>> g);
                    n_z[ln] = w_z[ln] + f_atan(g);
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_rx[g] <= n_x;
                r_ry[g] <= n_y;
                r_rz[g] <= n_z;
            end
        end
    end

    // ---------------------------------------------------------------
    // E1: cos1*cos2, sin1*sin2, sin^2 of mean latitude
    // ---------------------------------------------------------------
    logic signed [63:0] r_pcc, r_pss, r_psm;
    logic signed [31:0] r_cdf;
    logic signed [31:0] w_c1, w_c2, w_s1r, w_s2r, w_smr, w_cd, w_sdm;

    always_comb begin
        w_c1  = 32'(r_rx[N-1][0]);
        w_s1r = 32'(r_ry[N-1][0]);
        w_c2  = 32'(r_rx[N-1][1]);
        w_s2r = 32'(r_ry[N-1][1]);
        w_smr = 32'(r_ry[N-1][2]);
        w_cd  = 32'(r_rx[N-1][3]);
        w_sdm = 32'(r_ry[N-1][3]);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_pcc <= 64'(w_c1) * 64'(w_c2);
            r_pss <= 64'(w_s1r) * 64'(w_s2r);
            r_psm <= 64'(w_smr) * 64'(w_smr);
            r_cdf <= r_qp[N-1] ? -w_sdm : w_cd;
        end
    end

    // ---------------------------------------------------------------
    // E2: round cos1*cos2 and sin^2 to Q30, clamp sin^2 to one
    // ---------------------------------------------------------------
    logic signed [33:0] r_t2;
    logic signed [63:0] r_pss2;
    logic signed [31:0] r_cdf2;
    logic [30:0]        r_s2m;
    logic signed [63:0] w_tr, w_smq;

    always_comb begin
        w_tr  = (r_pcc + 64'sd536870912) >>> 30;
        w_smq = (r_psm + 64'sd536870912) >>> 30;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_t2   <= 34'(w_tr);
            r_pss2 <= r_pss;
            r_cdf2 <= r_cdf;
            r_s2m  <= (w_smq > 64'sd1073741824) ? 31'd1073741824 : 31'(w_smq);
        end
    end

    // ---------------------------------------------------------------
    // E3: cos1*cos2*cos(dlambda), f * sin^2
    // ---------------------------------------------------------------
    logic signed [63:0] r_ptcd, r_pss3;
    logic [63:0]        r_pfs;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_ptcd <= 64'(r_t2) * 64'(r_cdf2);
            r_pss3 <= r_pss2;
            r_pfs  <= 64'(f_flat_q40(r_sel)) * 64'(r_s2m);
        end
    end

    // ---------------------------------------------------------------
    // E4: cosine sum, fold to absolute value, clamp; round f*sin^2 to Q36
    // ---------------------------------------------------------------
    logic [30:0]        r_c;
    logic [29:0]        r_fs;
    logic signed [63:0] w_cs;
    logic signed [34:0] w_cq;
    logic [34:0]        w_ca;
    logic [63:0]        w_fsr;

    always_comb begin
        w_cs  = (r_pss3 + r_ptcd + 64'sd536870912) >>> 30;
        w_cq  = 35'(w_cs);
        w_ca  = w_cq[34] ? 35'(-w_cq) : 35'(w_cq);
        w_fsr = (r_pfs + 64'(64'd1 << 33)) >> 34;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_c  <= (w_ca > 35'd1073741824) ? 31'd1073741824 : w_ca[30:0];
            r_fs <= w_fsr[29:0];
        end
    end

    // ---------------------------------------------------------------
    // E5: 1 - c^2 in Q60, a * f sin^2
    // ---------------------------------------------------------------
    logic [60:0] r_v5;
    logic [30:0] r_c5;
    logic [63:0] r_pafs;
    logic [32:0] r_a5;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_v5   <= (61'd1 << 60) - 61'(r_c) * 61'(r_c);
            r_c5   <= r_c;
            r_pafs <= 64'(f_axis_mm(r_sel)) * 64'(r_fs);
            r_a5   <= f_axis_mm(r_sel);
        end
    end

    // ---------------------------------------------------------------
    // Square root: one result bit per stage; radius travels alongside
    // ---------------------------------------------------------------
    logic [60:0]        r_qv [ISQ_STAGES];
    logic [61:0]        r_qr [ISQ_STAGES];
    logic [30:0]        r_qc [ISQ_STAGES];
    logic [32:0]        r_rad [RDP];
    logic [63:0]        w_rafs;

    assign w_rafs = (r_pafs + 64'(64'd1 << 35)) >> 36;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_rad[0] <= r_a5 - w_rafs[32:0];
            for (int j = 1; j < RDP; j++) begin
                r_rad[j] <= r_rad[j-1];
            end
        end
    end

    for (genvar k = 0; k < ISQ_STAGES; k++) begin : g_isq
        localparam logic [61:0] BIT = 62'd1 << (60 - 2 * k);
        logic [60:0] w_v;
        logic [61:0] w_r, w_t;
        logic [30:0] w_c;
        logic [60:0] n_v;
        logic [61:0] n_r;

        always_comb begin
            if (k == 0) begin
                w_v = r_v5;
                w_r = '0;
                w_c = r_c5;
            end else begin
                w_v = r_qv[k-1];
                w_r = r_qr[k-1];
                w_c = r_qc[k-1];
            end
            w_t = w_r + BIT;
            if (62'(w_v) >= w_t) begin
                n_v = w_v - w_t[60:0];
                n_r = (w_r >> 1) + BIT;
            end else begin
                n_v = w_v;
                n_r = w_r >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_qv[k] <= n_v;
                r_qr[k] <= n_r;
                r_qc[k] <= w_c;
            end
        end
    end

    // ---------------------------------------------------------------
    // Vectoring CORDIC: angle of (c, sqrt(1 - c^2))
    // ---------------------------------------------------------------
    logic signed [ZW-1:0] r_vx [N];
    logic signed [ZW-1:0] r_vy [N];
    logic signed [ZW-1:0] r_vz [N];

    for (genvar g = 0; g < N; g++) begin : g_vec
        logic signed [ZW-1:0] w_x, w_y, w_z;
        logic signed [ZW-1:0] n_x, n_y, n_z;

        always_comb begin
            if (g == 0) begin
                w_x = ZW'(r_qc[ISQ_STAGES-1]);
                w_y = ZW'(r_qr[ISQ_STAGES-1][30:0]);
                w_z = '0;
            end else begin
                w_x = r_vx[g-1];
                w_y = r_vy[g-1];
                w_z = r_vz[g-1];
            end
            if (w_y > 0) begin
                n_x = w_x + (w_y >>> g);
                n_y = w_y - (w_x >>> g);
                n_z = w_z + f_atan(g);
            end else begin
                n_x = w_x - (w_y >>> g);
                n_y = w_y + (w_x >>> g);
                n_z = w_z - f_atan(g);
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_vx[g] <= n_x;
                r_vy[g] <= n_y;
                r_vz[g] <= n_z;
            end
        end
    end

    // ---------------------------------------------------------------
    // F1: clamp central angle, multiply by radius; F2: round to mm
    // ---------------------------------------------------------------
    logic [64:0]   r_pd;
    logic [33:0]   r_dist;
    logic [30:0]   w_delta;
    logic [64:0]   w_dr;

    always_comb begin
        if (r_vz[N-1] < 0)                w_delta = '0;
        else if (r_vz[N-1] > HALF_PI_Q30) w_delta = HALF_PI_Q30[30:0];
        else                              w_delta = r_vz[N-1][30:0];
        w_dr = (r_pd + 65'(1 << 29)) >> 30;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_pd   <= 65'(r_rad[RDP-1]) * 65'(w_delta);
            r_dist <= w_dr[33:0];
        end
    end

    assign o_distance_mm = r_dist;

endmodule

`default_nettype wire

/* design/egcd_checker.sv */
// Port-level checker for the ellipsoid great circle distance unit, with its bind.
// Depends on assert_macros.svh and ellipsoid_great_circle_distance_unit.
`default_nettype none
`include "assert_macros.svh"

module egcd_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_ready,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic [33:0] o_distance_mm
);

    // A stalled result stays offered.
    `EGCD_ASSERT(a_hold_valid, i_clk, i_rst_n, o_valid && !i_ready |=> o_valid, "result dropped while stalled")

    // A stalled result keeps its value.
    `EGCD_ASSERT(a_hold_data, i_clk, i_rst_n, o_valid && !i_ready |=> $stable(o_distance_mm), "result changed while stalled")

    // An empty output slot never blocks new requests.
    `EGCD_ASSERT(a_ready_free, i_clk, i_rst_n, !o_valid |-> o_ready, "request blocked with empty output")

    // Distance never exceeds 10020 km, just over a quarter circle on the largest semi-major axis.
    `EGCD_ASSERT(a_range, i_clk, i_rst_n, o_valid |-> o_distance_mm <= 34'd10020000000, "distance out of range")

    // Reset empties the output.
    `EGCD_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_valid, "output valid after reset")

endmodule

bind ellipsoid_great_circle_distance_unit egcd_checker u_egcd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_ready       (o_ready),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_distance_mm (o_distance_mm)
);

`default_nettype wire
